### sv/b64se_pkg.sv
// shared types, constants and the sextet-to-ascii mapping for the base64 encoder
// no dependencies
package b64se_pkg;

    localparam int Q_DEPTH = 2;
    localparam int QADDR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_text;
    } t_out_item;

    typedef struct packed {
        logic       is_pad;
        logic [5:0] sextet;
    } t_sym;

    // one accepted byte turned into up to four symbols
    typedef struct packed {
        t_sym [3:0] syms;
        logic [1:0] last_idx;
        logic       fin;
    } t_cmd;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] r;
        w = {2'b00, v};
        if (v < 6'd26) begin
            r = 8'h41 + w;
        end else if (v < 6'd52) begin
            r = 8'h61 + w - 8'd26;
        end else if (v < 6'd62) begin
            r = 8'h30 + w - 8'd52;
        end else if (v == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic logic [7:0] sym_to_char(input t_sym s);
        return s.is_pad ? PAD_CHAR : sextet_to_char(s.sextet);
    endfunction

endpackage

### sv/b64se_front.sv
// front end: accepts bytes, tracks carry bits and group phase, builds symbol commands
// depends on b64se_pkg
module b64se_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64se_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output b64se_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;

    b64se_pkg::t_sym pad_sym;
    logic [7:0]      b;
    logic            fin;

    assign pad_sym = '{is_pad: 1'b1, sextet: 6'd0};
    assign b       = i_item.data_byte;
    assign fin     = i_item.final_byte;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_cmd.syms[2] = pad_sym;
        o_cmd.syms[3] = pad_sym;
        o_cmd.fin     = fin;
        case (r_phase)
            PH_SECOND: begin
                o_cmd.syms[0] = '{is_pad: 1'b0, sextet: {r_carry[1:0], b[7:4]}};
                o_cmd.syms[1] = '{is_pad: 1'b0, sextet: {b[3:0], 2'b00}};
                o_cmd.last_idx = fin ? 2'd2 : 2'd0;
                n_carry = b[3:0];
                n_phase = PH_THIRD;
            end
            PH_THIRD: begin
                o_cmd.syms[0] = '{is_pad: 1'b0, sextet: {r_carry, b[7:6]}};
                o_cmd.syms[1] = '{is_pad: 1'b0, sextet: b[5:0]};
                o_cmd.last_idx = 2'd1;
                n_carry = 4'd0;
                n_phase = PH_FIRST;
            end
            default: begin
                o_cmd.syms[0] = '{is_pad: 1'b0, sextet: b[7:2]};
                o_cmd.syms[1] = '{is_pad: 1'b0, sextet: {b[1:0], 4'b0000}};
                o_cmd.last_idx = fin ? 2'd3 : 2'd0;
                n_carry = {2'b00, b[1:0]};
                n_phase = PH_SECOND;
            end
        endcase
        // end of message restarts the group
        if (fin) begin
            n_carry = 4'd0;
            n_phase = PH_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_carry <= 4'd0;
        end else if (o_q_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

### sv/b64se_queue.sv
// short command queue between front and back end
// depends on b64se_pkg
module b64se_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64se_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output b64se_pkg::t_cmd o_cmd,
    output logic            o_empty
);

    b64se_pkg::t_cmd r_mem [b64se_pkg::Q_DEPTH];
    logic [b64se_pkg::QADDR_W-1:0] r_wptr, r_rptr;
    logic [b64se_pkg::QCNT_W-1:0]  r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == b64se_pkg::QCNT_W'(b64se_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    function automatic logic [b64se_pkg::QADDR_W-1:0] inc_ptr(
        input logic [b64se_pkg::QADDR_W-1:0] p
    );
        return (p == b64se_pkg::QADDR_W'(b64se_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= inc_ptr(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= inc_ptr(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/b64se_back.sv
// back end: steps through each command's symbols, one ascii character per cycle
// while a command is queued and the output is free; depends on b64se_pkg
module b64se_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64se_pkg::t_cmd     i_cmd,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output b64se_pkg::t_out_item o_item
);

    logic [1:0]               r_idx;
    logic                     r_valid;
    b64se_pkg::t_out_item     r_out;

    logic load;
    logic at_last;

    // output register is free when empty or being drained this cycle
    assign load    = (!r_valid || i_pop) && !i_q_empty;
    assign at_last = (r_idx == i_cmd.last_idx);
    assign o_q_pop = load && at_last;
    assign o_empty = !r_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_char    <= b64se_pkg::sym_to_char(i_cmd.syms[r_idx]);
            r_out.end_of_text <= i_cmd.fin && at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### sv/base64_stream_encoder.sv
// top level of the streaming base64 encoder: front end, command queue, back end
// depends on b64se_pkg, b64se_front, b64se_queue, b64se_back
//
//  channel   handshake        payload          direction
//  input     i_push / o_full  i_item           bytes in, final_byte marks message end
//  result    o_empty / i_pop  o_item           ascii characters out, end_of_text on last
//
// a byte is taken when pushed while the queue is not full and turned into one to four symbols in the queue
// the back end sends one character per cycle while the receiver pops and commands are queued; a byte yields
// 4/3 characters on average, up to 4 on a message's final byte
// the output register accepts a new character in the cycle its current one is popped
// synchronous active-low reset clears the group phase, carry bits, queue and output
module base64_stream_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64se_pkg::t_in_item  i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output b64se_pkg::t_out_item o_item
);

    b64se_pkg::t_cmd front_cmd;
    b64se_pkg::t_cmd head_cmd;
    logic            q_push, q_full, q_pop, q_empty;

    assign o_full = q_full;

    b64se_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    b64se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    b64se_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_item    (o_item)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// testbench for base64_stream_encoder: directed and random messages through the queue handshakes
// depends on b64se_pkg and base64_stream_encoder; expected characters come from an in-bench encoder
module tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTS   = 30;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_push  = 1'b0;
    logic                 i_pop   = 1'b0;
    b64se_pkg::t_in_item  i_item  = '0;
    logic                 o_full;
    logic                 o_empty;
    b64se_pkg::t_out_item o_item;

    base64_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // encoder state as the bench sees it
    logic [3:0] held_bits = '0;
    logic [1:0] byte_pos  = '0;

    b64se_pkg::t_in_item  byte_q[$];
    b64se_pkg::t_out_item char_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_budget    = 0;
    int holds_taken    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int n_errors = 0;
    int n_bytes  = 0;
    int n_msgs   = 0;
    int n_chars  = 0;
    int n_queued = 0;

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    task automatic add_char(input logic [7:0] ch, input logic eot);
        b64se_pkg::t_out_item c;
        c.out_char    = ch;
        c.end_of_text = eot;
        char_q.push_back(c);
    endtask

    function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
        return alphabet[int'(v)];
    endfunction

    task automatic encode_byte(input b64se_pkg::t_in_item it);
        logic [7:0] b;
        logic       fin;
        b   = it.data_byte;
        fin = it.final_byte;
        case (byte_pos)
            2'd1: begin
                add_char(sextet_ascii({held_bits[1:0], b[7:4]}), 1'b0);
                held_bits = b[3:0];
                if (fin) begin
                    add_char(sextet_ascii({held_bits, 2'b00}), 1'b0);
                    add_char(b64se_pkg::PAD_CHAR, 1'b1);
                end
                byte_pos = 2'd2;
            end
            2'd2: begin
                add_char(sextet_ascii({held_bits, b[7:6]}), 1'b0);
                add_char(sextet_ascii(b[5:0]), fin);
                held_bits = '0;
                byte_pos  = 2'd0;
            end
            default: begin
                // unused position 3 behaves like the start of a group
                add_char(sextet_ascii(b[7:2]), 1'b0);
                held_bits = {2'b00, b[1:0]};
                if (fin) begin
                    add_char(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
                    add_char(b64se_pkg::PAD_CHAR, 1'b0);
                    add_char(b64se_pkg::PAD_CHAR, 1'b1);
                end
                byte_pos = 2'd1;
            end
        endcase
        if (fin) begin
            held_bits = '0;
            byte_pos  = 2'd0;
            n_msgs++;
        end
    endtask

    // driver: offers queued bytes, holds an item until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                encode_byte(i_item);
                n_bytes++;
            end
            if (!i_push || !o_full) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_push <= 1'b1;
                    i_item <= byte_q.pop_front();
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each popped character and decides the next pop
    always @(posedge i_clk) begin : monitor
        b64se_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (char_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h eot %0b",
                                              o_item.out_char, o_item.end_of_text));
                end else begin
                    want = char_q.pop_front();
                    if (o_item.out_char !== want.out_char) begin
                        report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                                  o_item.out_char, want.out_char));
                    end
                    if (o_item.end_of_text !== want.end_of_text) begin
                        report_mismatch($sformatf("end_of_text %0b on char 0x%02h, want %0b",
                                                  o_item.end_of_text, want.out_char,
                                                  want.end_of_text));
                    end
                    n_chars++;
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_pop     <= 1'b0;
            end else if (holds_taken < hold_budget) begin
                // long hold-off so the encoder backs up and raises full
                holds_taken <= holds_taken + 1;
                hold_left   <= HOLD_CYCLES;
                i_pop       <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("base64_stream_encoder test failed");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        b64se_pkg::t_in_item it;
        it.data_byte  = b;
        it.final_byte = fin;
        byte_q.push_back(it);
        n_queued++;
    endtask

    task automatic queue_messages(input int n_items);
        int target;
        int len;
        target = n_queued + n_items;
        while (n_queued < target) begin
            // mostly short messages so every group position ends a message often
            len = ($urandom_range(4) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++) begin
                queue_byte(8'($urandom_range(255)), k == len - 1);
            end
        end
    endtask

    task automatic wait_drain();
        while (byte_q.size() != 0 || i_push || char_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                             input bit pressure);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_messages(n_items);
        if (pressure) begin
            hold_budget++;
        end
        wait_drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one to six byte messages, all-zero and all-one bytes, '+' and '/'
        @(negedge i_clk);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h83, 1'b1);
        queue_byte(8'h14, 1'b0);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'h9C, 1'b0);
        queue_byte(8'h03, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b1);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h0F, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFE, 1'b1);
        wait_drain();

        run_phase(0, 0, 110, 1'b0);
        run_phase(49, 0, 110, 1'b0);
        run_phase(0, 49, 110, 1'b1);
        run_phase(8, 8, 110, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (char_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected chars never came out", char_q.size()));
        end

        $display("encoded %0d bytes in %0d messages, %0d chars checked, %0d mismatches",
                 n_bytes, n_msgs, n_chars, n_errors);
        $display("timing mixes: free flow, sender gaps, receiver stalls with a long hold, both");
        if (n_errors == 0) begin
            $display("base64_stream_encoder test passed");
        end else begin
            $display("base64_stream_encoder test failed");
        end
        $finish;
    end

endmodule
